FILE: design/fosl_pkg.sv
package fosl_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = 18;
  localparam int HIST_W         = SAMPLE_WIDTH + 2;

  // accumulator must hold the iir sum and the scaled shelf sum
  localparam int AccIir   = HIST_W + COEF_W + 2;
  localparam int AccShelf = HIST_W + 1 + COEF_FRAC_BITS + 2;
  localparam int ACC_W    = (AccIir > AccShelf) ? AccIir : AccShelf;

  // bit counter for the serial coefficient
  localparam int CNT_W = $clog2(COEF_W);

  // configuration port
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_B0    = 2'd0,
    CFG_COEF_B1    = 2'd1,
    CFG_COEF_A1    = 2'd2,
    CFG_SHELF_GAIN = 2'd3
  } cfg_idx_e;

  // reset values of the registers
  localparam longint CoefOne = longint'(1) << COEF_FRAC_BITS;
  localparam longint CoefMax = (longint'(1) << (COEF_W - 1)) - 1;
  localparam longint GainMax = (longint'(1) << COEF_W) - 1;
  localparam longint B1Raw   = (CoefOne > CoefMax + 1) ? -(CoefMax + 1) : -CoefOne;
  localparam longint GainRaw = (12 * CoefOne + 5) / 10;

  localparam logic [COEF_W-1:0] B1_RESET   = COEF_W'(B1Raw);
  localparam logic [COEF_W-1:0] GAIN_RESET = COEF_W'((GainRaw > GainMax) ? GainMax : GainRaw);

  // rounding offset for the iir section
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] a1;
    logic        [COEF_W-1:0] gain;
  } cfg_t;

  // commands to the serial multiply-accumulate unit
  typedef struct packed {
    logic                    load_acc;
    logic signed [ACC_W-1:0] acc_init;
    logic                    start;
    logic signed [ACC_W-1:0] mcand;
    logic        [COEF_W-1:0] coef;
    logic                    coef_signed;
    logic                    negate;
  } mac_ctrl_t;

  typedef struct packed {
    logic                    last;
    logic signed [ACC_W-1:0] acc;
  } mac_stat_t;

endpackage

FILE: design/fosl_if.sv
interface fosl_in_if
  import fosl_pkg::*;
();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fosl_out_if
  import fosl_pkg::*;
();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: design/fosl_cfg_regs.sv
module fosl_cfg_regs
  import fosl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_B0:    cfg_d.b0   = cfg_data_i;
        CFG_COEF_B1:    cfg_d.b1   = cfg_data_i;
        CFG_COEF_A1:    cfg_d.a1   = cfg_data_i;
        CFG_SHELF_GAIN: cfg_d.gain = cfg_data_i;
        default:        cfg_d      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0   <= '0;
      cfg_q.b1   <= B1_RESET;
      cfg_q.a1   <= '0;
      cfg_q.gain <= GAIN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/fosl_mac.sv
module fosl_mac
  import fosl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  output mac_stat_t stat_o
);

  localparam logic [CNT_W-1:0] CntLast = CNT_W'(COEF_W - 1);

  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  mcand_q;
  logic        [COEF_W-1:0] coef_q;
  logic        [CNT_W-1:0]  cnt_q;
  logic                     busy_q;
  logic                     sgn_q;
  logic                     neg_q;

  logic                     last;
  logic                     neg_step;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_sum;

  // one coefficient bit per cycle, lsb first; the sign bit of a signed
  // coefficient carries negative weight
  always_comb begin
    last     = busy_q && (cnt_q == CntLast);
    neg_step = neg_q ^ (sgn_q && last);
    addend   = mcand_q ^ {ACC_W{neg_step}};
    acc_sum  = acc_q + addend + ACC_W'(neg_step);
    if (ctrl_i.load_acc) begin
      acc_d = ctrl_i.acc_init;
    end else if (busy_q && coef_q[0]) begin
      acc_d = acc_sum;
    end else begin
      acc_d = acc_q;
    end
  end

  // sequencing of the bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // multiplicand shifts left, coefficient shifts right
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl_i.start) begin
      mcand_q <= ctrl_i.mcand;
      coef_q  <= ctrl_i.coef;
      sgn_q   <= ctrl_i.coef_signed;
      neg_q   <= ctrl_i.negate;
    end else if (busy_q) begin
      mcand_q <= {mcand_q[ACC_W-2:0], 1'b0};
      coef_q  <= {1'b0, coef_q[COEF_W-1:1]};
    end
  end

  assign stat_o.last = last;
  assign stat_o.acc  = acc_q;

endmodule

FILE: design/first_order_shelving_lowpass.sv
// First-order shelving low-pass for one audio channel.
// Input channel in_i carries one signed Q0.23 sample per word; output
// channel out_o returns one filtered, saturated Q0.23 sample per word.
// A word moves when valid and ready are both high at a rising edge.
// Coefficients b0, b1, a1 (signed Q1.16) and shelf gain k (unsigned Q2.16)
// are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must
// write them only while idle, as the block itself does not enforce this.
// Every sample runs through one shared bit-serial multiply-accumulate unit
// that takes one coefficient bit per cycle: three products for the iir
// section, a step to round and saturate the history, a step to form the
// sum and difference, one product for the shelf gain and a step to round
// and saturate the result. A new word is accepted only once the previous
// result has left the final state for the output register.
// The result sits in an output register, so the next sample is taken and
// processed while out_o is stalled; a finished result waits in the final
// state until the output register is free.
// Reset clears both history registers, loads the default coefficients
// (b0 = 0, b1 = -1.0, a1 = 0, k = 1.2) and empties the output register.
module first_order_shelving_lowpass
  import fosl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  fosl_in_if.sink              in_i,
  fosl_out_if.source           out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B0,
    ST_B1,
    ST_A1,
    ST_FIX,
    ST_PREP,
    ST_GAIN,
    ST_SAT
  } state_e;

  localparam int FqW = ACC_W - COEF_FRAC_BITS;
  localparam int YqW = ACC_W - COEF_FRAC_BITS - 1;

  state_e                         state_q, state_d;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] xh_q;
  logic signed [HIST_W-1:0]       yh_q;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_q;

  cfg_t                           cfg;
  mac_ctrl_t                      mac_ctrl;
  mac_stat_t                      mac_stat;

  logic signed [FqW-1:0]          fq;
  logic signed [HIST_W-1:0]       f_sat;
  logic signed [YqW-1:0]          yq;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [HIST_W:0]         s_inc;
  logic signed [HIST_W:0]         diff;
  logic                           in_acc;
  logic                           out_free;

  fosl_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fosl_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .stat_o (mac_stat)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;

  // round and saturate the iir result to the history width
  always_comb begin
    fq = mac_stat.acc[ACC_W-1:COEF_FRAC_BITS];
    if (fq[FqW-1:HIST_W-1] != {(FqW - HIST_W + 1){fq[FqW-1]}}) begin
      f_sat = {fq[FqW-1], {(HIST_W - 1){~fq[FqW-1]}}};
    end else begin
      f_sat = fq[HIST_W-1:0];
    end
  end

  // round and saturate the shelf result to the sample width
  always_comb begin
    yq = mac_stat.acc[ACC_W-1:COEF_FRAC_BITS+1];
    if (yq[YqW-1:SAMPLE_WIDTH-1] != {(YqW - SAMPLE_WIDTH + 1){yq[YqW-1]}}) begin
      y_sat = {yq[YqW-1], {(SAMPLE_WIDTH - 1){~yq[YqW-1]}}};
    end else begin
      y_sat = yq[SAMPLE_WIDTH-1:0];
    end
  end

  // sum (with the rounding one folded in) and difference of x and f
  always_comb begin
    s_inc = (HIST_W + 1)'(x_q) + (HIST_W + 1)'(yh_q) + (HIST_W + 1)'(1);
    diff  = (HIST_W + 1)'(x_q) - (HIST_W + 1)'(yh_q);
  end

  // sequencer commands and next state
  always_comb begin
    state_d  = state_q;
    mac_ctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        mac_ctrl.mcand       = ACC_W'(in_i.sample_in);
        mac_ctrl.coef        = cfg.b0;
        mac_ctrl.coef_signed = 1'b1;
        mac_ctrl.acc_init    = ACC_RND;
        if (in_acc) begin
          mac_ctrl.load_acc = 1'b1;
          mac_ctrl.start    = 1'b1;
          state_d           = ST_B0;
        end
      end
      ST_B0: begin
        mac_ctrl.mcand       = ACC_W'(xh_q);
        mac_ctrl.coef        = cfg.b1;
        mac_ctrl.coef_signed = 1'b1;
        if (mac_stat.last) begin
          mac_ctrl.start = 1'b1;
          state_d        = ST_B1;
        end
      end
      ST_B1: begin
        mac_ctrl.mcand       = ACC_W'(yh_q);
        mac_ctrl.coef        = cfg.a1;
        mac_ctrl.coef_signed = 1'b1;
        mac_ctrl.negate      = 1'b1;
        if (mac_stat.last) begin
          mac_ctrl.start = 1'b1;
          state_d        = ST_A1;
        end
      end
      ST_A1: begin
        if (mac_stat.last) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        mac_ctrl.load_acc    = 1'b1;
        mac_ctrl.acc_init    = {(ACC_W - COEF_FRAC_BITS)'(s_inc), {COEF_FRAC_BITS{1'b0}}};
        mac_ctrl.start       = 1'b1;
        mac_ctrl.mcand       = ACC_W'(diff);
        mac_ctrl.coef        = cfg.gain;
        mac_ctrl.coef_signed = 1'b0;
        state_d              = ST_GAIN;
      end
      ST_GAIN: begin
        if (mac_stat.last) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, history and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      xh_q        <= '0;
      yh_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        x_q <= in_i.sample_in;
      end
      if (state_q == ST_FIX) begin
        yh_q <= f_sat;
      end
      if (state_q == ST_PREP) begin
        xh_q <= x_q;
      end
      if ((state_q == ST_SAT) && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= y_sat;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule

FILE: sim/fosl_tb_pkg.sv
`timescale 1ns / 1ps

package fosl_tb_pkg;
  import fosl_pkg::*;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // tracks filter state and the samples still due on the output channel
  class shelf_scoreboard;
    longint  b0, b1, a1, gain;
    longint  x_prev, f_prev;
    sample_t pending_out[$];
    int unsigned errors;

    function new();
      longint one;
      one    = longint'(1) << COEF_FRAC_BITS;
      b0     = 0;
      b1     = -one;
      a1     = 0;
      gain   = (12 * one + 5) / 10;
      x_prev = 0;
      f_prev = 0;
      errors = 0;
    endfunction

    // round to nearest, ties toward +inf, then arithmetic shift
    static function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    static function longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [COEF_W-1:0] data);
      case (idx)
        CFG_COEF_B0:    b0 = signed'(data);
        CFG_COEF_B1:    b1 = signed'(data);
        CFG_COEF_A1:    a1 = signed'(data);
        CFG_SHELF_GAIN: gain = data;
        default: ;
      endcase
    endfunction

    // iir section, then shelf mix of sum and difference halves
    function void take_sample(sample_t x_in);
      longint x, acc, f, s, d, sh, sl, y;
      x   = x_in;
      acc = b0 * x + b1 * x_prev - a1 * f_prev;
      f   = clamp(round_shift(acc, COEF_FRAC_BITS), HIST_W);
      x_prev = x;
      f_prev = f;
      s  = x + f;
      d  = x - f;
      sh = s >>> 1;
      sl = s - 2 * sh;
      y  = sh + round_shift(sl * (longint'(1) << COEF_FRAC_BITS) + gain * d,
                            COEF_FRAC_BITS + 1);
      y  = clamp(y, SAMPLE_WIDTH);
      pending_out.push_back(sample_t'(y));
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (pending_out.size() == 0) begin
        $error("sample_out: unexpected word, actual %0d", got);
        errors++;
      end else begin
        want = pending_out.pop_front();
        if (got !== want) begin
          $error("sample_out mismatch: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

FILE: sim/first_order_shelving_lowpass_tb.sv
`timescale 1ns / 1ps

module first_order_shelving_lowpass_tb;
  import fosl_pkg::*;
  import fosl_tb_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_OFF     = 400;
  localparam int DRAIN_CYCLES = 80;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  cfg_idx_e          cfg_idx = CFG_COEF_B0;
  logic [COEF_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  fosl_in_if  in_if ();
  fosl_out_if out_if ();

  shelf_scoreboard sb = new();

  first_order_shelving_lowpass i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_OFF;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // check each word leaving the block
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_sample(out_if.sample_out);
  end

  task automatic write_config(int b0, int b1, int a1, int gain);
    cfg_idx_e idx [4];
    int       val [4];
    idx = '{CFG_COEF_B0, CFG_COEF_B1, CFG_COEF_A1, CFG_SHELF_GAIN};
    val = '{b0, b1, a1, gain};
    for (int i = 0; i < 4; i++) begin
      cfg_we   = 1'b1;
      cfg_idx  = idx[i];
      cfg_data = COEF_W'(val[i]);
      sb.write_reg(idx[i], cfg_data);
      @(negedge clk_i);
    end
    cfg_we = 1'b0;
  endtask

  // offer one word, entered and left at a falling edge
  task automatic send_sample(sample_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.sample_in = x;
    do @(posedge clk_i); while (!in_if.ready);
    sb.take_sample(x);
    @(negedge clk_i);
  endtask

  task automatic send_list(sample_t vals[$]);
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  task automatic finish_phase();
    in_if.valid = 1'b0;
    while (sb.pending_out.size() != 0) @(negedge clk_i);
  endtask

  // mix of full-range, quiet and extreme samples
  function automatic sample_t rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return sample_t'($urandom);
    if (pick < 85) return sample_t'(int'($urandom_range(0, 8190)) - 4095);
    case ($urandom_range(3))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // stable audio-like, coarse (more rounding ties) or fully random settings
  function automatic int rand_coef(int kind, int span);
    case (kind)
      0:       return int'($urandom_range(0, 2 * span)) - span;
      1:       return int'($urandom_range(0, 31)) << 13;
      default: return int'($urandom_range(0, 262143));
    endcase
  endfunction

  initial begin
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset coefficients: full-scale steps and alternating patterns
    send_list('{sample_t'(0), SAMPLE_MAX, SAMPLE_MIN, sample_t'(-1), sample_t'(1),
                SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                sample_t'(24'h555555), sample_t'(24'haaaaaa)});
    finish_phase();

    // extreme coefficients: history and output saturation
    write_config(-131072, -131072, 131071, 262143);
    send_list('{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, sample_t'(0),
                sample_t'(1), sample_t'(-1)});
    finish_phase();

    // half-weight section, unity gain: odd samples land on rounding ties
    write_config(32768, 0, 0, 65536);
    send_list('{sample_t'(1), sample_t'(3), sample_t'(-1), sample_t'(-3), SAMPLE_MAX});
    finish_phase();

    // opposite extremes, zero shelf gain
    write_config(131071, 131071, -131072, 0);
    send_list('{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX});
    finish_phase();

    // random phases across idling modes
    for (int p = 0; p < RAND_PHASES; p++) begin
      int kind;
      kind = p % 3;
      case (p / 3)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_config(rand_coef(kind, 65536), rand_coef(kind, 65536),
                   rand_coef(kind, 62000), int'($urandom_range(0, 262143)));
      if (p == 6) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_sample(rand_sample());
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_out.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

endmodule
